// ===== hw/rtl/mtf_pkg.sv =====
// Shared types and constants for the matrix trace / Frobenius norm accumulator.
// Used by mtf_ctrl, mtf_datapath and the top level. No dependencies.
package mtf_pkg;

   // rows at or above this are never treated as diagonal
   localparam int MAX_DIM = 4096;
   localparam int DIM_W   = 17;

   localparam logic signed [47:0] ACC48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] ACC48_MIN = 48'sh8000_0000_0000;
   localparam logic signed [31:0] ACC32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] ACC32_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_SAT,
      ST_SQ,
      ST_TOT
   } mtf_state_type;

   typedef struct packed {
      logic load;   // capture the input item
      logic mul;    // register the two products
      logic acc;    // update the entry accumulator
      logic sat;    // clamp entry to Q16.16, magnitude, diagonal flag
      logic sq;     // square and trace candidate
      logic emit;   // load output register, update totals
   } mtf_cmd_type;

   typedef struct packed {
      logic last_term;
      logic out_free;
   } mtf_status_type;

endpackage

// ===== hw/rtl/mtf_ctrl.sv =====
// Controller state machine for the accumulator.
// Depends on mtf_pkg; drives mtf_datapath through a command struct.
module mtf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mtf_pkg::mtf_status_type status,
   output mtf_pkg::mtf_cmd_type    cmd
);
   import mtf_pkg::*;

   mtf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.last_term ? ST_SAT : ST_IDLE;
         end
         ST_SAT: begin
            cmd.sat  = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_TOT;
         end
         ST_TOT: begin
            // hold here until the output register can take the item
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/mtf_datapath.sv =====
// Datapath: operand capture, products, entry accumulator, saturation,
// square, running trace and norm, output register. Depends on mtf_pkg.
module mtf_datapath #(
   parameter int MAX_DIM = mtf_pkg::MAX_DIM
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mtf_pkg::mtf_cmd_type    cmd,
   output mtf_pkg::mtf_status_type status,
   input  logic [11:0]            req_row_index,
   input  logic [11:0]            req_col_index,
   input  logic signed [15:0]     req_m_value,
   input  logic signed [15:0]     req_x_val,
   input  logic signed [15:0]     req_z_val,
   input  logic signed [15:0]     req_q_val,
   input  logic signed [15:0]     req_j_val,
   input  logic                   req_last_term,
   input  logic                   req_last_entry,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [31:0]     rsp_entry_value,
   output logic                   rsp_is_diagonal,
   output logic signed [47:0]     rsp_trace_sum,
   output logic [63:0]            rsp_hs_norm,
   output logic                   rsp_matrix_done
);
   import mtf_pkg::*;

   // captured item
   logic [11:0]        row_ff, col_ff;
   logic signed [15:0] m_ff, x_ff, z_ff, q_ff, j_ff;
   logic               last_term_ff, last_entry_ff;

   logic signed [31:0] p1_ff, p2_ff;
   logic signed [47:0] entry_acc_ff;
   logic               entry_open_ff;
   logic signed [31:0] e_ff;
   logic [31:0]        mag_ff;
   logic               diag_ff;
   logic [63:0]        sq_ff;
   logic signed [47:0] trace_nx_ff;
   logic signed [47:0] trace_acc_ff;
   logic [63:0]        norm_acc_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_entry_value_ff;
   logic               rsp_is_diagonal_ff;
   logic signed [47:0] rsp_trace_sum_ff;
   logic [63:0]        rsp_hs_norm_ff;
   logic               rsp_matrix_done_ff;

   logic signed [32:0] term;
   logic signed [47:0] base;
   logic signed [48:0] acc_sum;
   logic signed [47:0] acc_sat;
   logic               ovf32;
   logic signed [31:0] e_in;
   logic [31:0]        mag_in;
   logic               diag_in;
   logic signed [48:0] trace_sum;
   logic signed [47:0] trace_sat;
   logic [64:0]        norm_sum;
   logic [63:0]        norm_sat;

   always_comb begin
      term    = 33'(p1_ff) - 33'(p2_ff);
      base    = entry_open_ff ? entry_acc_ff
                              : $signed({{24{m_ff[15]}}, m_ff, 8'h00});
      acc_sum = 49'(base) + 49'(term);
      if (acc_sum[48] != acc_sum[47]) begin
         acc_sat = acc_sum[48] ? ACC48_MIN : ACC48_MAX;
      end else begin
         acc_sat = acc_sum[47:0];
      end

      // Q32.16 down to Q16.16: bits 47..31 must all match the sign
      ovf32 = !((&entry_acc_ff[47:31]) || !(|entry_acc_ff[47:31]));
      if (ovf32) begin
         e_in = entry_acc_ff[47] ? ACC32_MIN : ACC32_MAX;
      end else begin
         e_in = entry_acc_ff[31:0];
      end
      mag_in  = e_in[31] ? (~e_in + 32'd1) : e_in;
      diag_in = (row_ff == col_ff) && ({5'b0, row_ff} < DIM_W'(MAX_DIM));

      trace_sum = 49'(trace_acc_ff) + 49'(e_ff);
      if (trace_sum[48] != trace_sum[47]) begin
         trace_sat = trace_sum[48] ? ACC48_MIN : ACC48_MAX;
      end else begin
         trace_sat = trace_sum[47:0];
      end

      norm_sum = {1'b0, norm_acc_ff} + {1'b0, sq_ff};
      norm_sat = norm_sum[64] ? {64{1'b1}} : norm_sum[63:0];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff        <= req_row_index;
         col_ff        <= req_col_index;
         m_ff          <= req_m_value;
         x_ff          <= req_x_val;
         z_ff          <= req_z_val;
         q_ff          <= req_q_val;
         j_ff          <= req_j_val;
         last_term_ff  <= req_last_term;
         last_entry_ff <= req_last_entry;
      end
      if (cmd.mul) begin
         p1_ff <= 32'(x_ff) * 32'(z_ff);
         p2_ff <= 32'(q_ff) * 32'(j_ff);
      end
      if (cmd.sat) begin
         e_ff    <= e_in;
         mag_ff  <= mag_in;
         diag_ff <= diag_in;
      end
      if (cmd.sq) begin
         sq_ff       <= 64'(mag_ff) * 64'(mag_ff);
         trace_nx_ff <= diag_ff ? trace_sat : trace_acc_ff;
      end
      if (cmd.emit) begin
         rsp_entry_value_ff <= e_ff;
         rsp_is_diagonal_ff <= diag_ff;
         rsp_trace_sum_ff   <= trace_nx_ff;
         rsp_hs_norm_ff     <= norm_sat;
         rsp_matrix_done_ff <= last_entry_ff;
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_acc_ff  <= '0;
         entry_open_ff <= 1'b0;
         trace_acc_ff  <= '0;
         norm_acc_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.acc) begin
            entry_acc_ff  <= acc_sat;
            entry_open_ff <= !last_term_ff;
         end
         if (cmd.emit) begin
            // totals restart after the item that closes the matrix
            trace_acc_ff <= last_entry_ff ? '0 : trace_nx_ff;
            norm_acc_ff  <= last_entry_ff ? '0 : norm_sat;
         end
         rsp_valid_ff <= cmd.emit || (rsp_valid_ff && rsp_stall);
      end
   end

   assign status.last_term = last_term_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_entry_value = rsp_entry_value_ff;
   assign rsp_is_diagonal = rsp_is_diagonal_ff;
   assign rsp_trace_sum   = rsp_trace_sum_ff;
   assign rsp_hs_norm     = rsp_hs_norm_ff;
   assign rsp_matrix_done = rsp_matrix_done_ff;

endmodule

// ===== hw/rtl/matrix_trace_frobenius_accumulator.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  row, col, M, X, Z, Q, J, last marks
// rsp_      out        rsp_valid/rsp_stall  entry, diagonal flag, trace, norm, done
//
// A term that does not end an entry passes through capture, products, accumulate.
// A last term adds clamp, square and totals, and waits in totals while the
// output register is still occupied; each step is a state of its own.
// The output register lets a new term be taken while a result waits.
// Synchronous active-high reset clears accumulator, totals and output valid.
// Top level: joins mtf_ctrl and mtf_datapath. Depends on mtf_pkg.
module matrix_trace_frobenius_accumulator #(
   parameter int MAX_DIM = mtf_pkg::MAX_DIM
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_row_index,
   input  logic [11:0]        req_col_index,
   input  logic signed [15:0] req_m_value,
   input  logic signed [15:0] req_x_val,
   input  logic signed [15:0] req_z_val,
   input  logic signed [15:0] req_q_val,
   input  logic signed [15:0] req_j_val,
   input  logic               req_last_term,
   input  logic               req_last_entry,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_is_diagonal,
   output logic signed [47:0] rsp_trace_sum,
   output logic [63:0]        rsp_hs_norm,
   output logic               rsp_matrix_done
);
   import mtf_pkg::*;

   mtf_cmd_type    cmd;
   mtf_status_type status;

   mtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mtf_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_m_value     (req_m_value),
      .req_x_val       (req_x_val),
      .req_z_val       (req_z_val),
      .req_q_val       (req_q_val),
      .req_j_val       (req_j_val),
      .req_last_term   (req_last_term),
      .req_last_entry  (req_last_entry),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_entry_value (rsp_entry_value),
      .rsp_is_diagonal (rsp_is_diagonal),
      .rsp_trace_sum   (rsp_trace_sum),
      .rsp_hs_norm     (rsp_hs_norm),
      .rsp_matrix_done (rsp_matrix_done)
   );

endmodule

// ===== hw/rtl/mtf_checker.sv =====
// Port-level checks for the accumulator, bound to the top level.
// No package dependency; sees the top-level ports only.
module mtf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_entry_value,
   input logic [63:0]        rsp_hs_norm
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   // one item in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again before the previous item was worked");

   // a new result only comes out of the busy phase of a last term
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

   // the norm includes this entry's square, so a non-zero entry means non-zero norm
   a_norm_covers_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_value != 32'sd0) |-> (rsp_hs_norm != 64'd0))
      else $error("norm is zero after a non-zero entry");

endmodule

bind matrix_trace_frobenius_accumulator mtf_checker u_mtf_checker (.*);
